/* src/lspt_pkg.sv */
// Shared types, register indexes and frame decode tables for the line sensor tracker.
// No dependencies; imported by lspt_classify, the top level and the checker.
package lspt_pkg;

   localparam int SENSOR_WIDTH = 8;
   localparam int FRAME_WIDTH  = 4;
   localparam int POS_WIDTH    = 3;
   localparam int COUNT_WIDTH  = 8;
   localparam int CONF_WIDTH   = 7;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;
   localparam int STEP_WIDTH   = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ADJACENT_STEP      = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_JUMP_ACCEPT_FRAMES = 2'd1;

   localparam logic [STEP_WIDTH-1:0]     ADJACENT_STEP_RESET = 3'd1;
   localparam logic [COUNT_WIDTH-1:0]    JUMP_ACCEPT_RESET   = 8'd3;
   localparam logic [COUNT_WIDTH-1:0]    COUNT_MAX           = 8'hFF;

   localparam logic [CONF_WIDTH-1:0] CONF_NONE   = 7'd0;
   localparam logic [CONF_WIDTH-1:0] CONF_WIDE   = 7'd45;
   localparam logic [CONF_WIDTH-1:0] CONF_EDGE   = 7'd55;
   localparam logic [CONF_WIDTH-1:0] CONF_PAIR   = 7'd80;
   localparam logic [CONF_WIDTH-1:0] CONF_INNER  = 7'd90;
   localparam logic [CONF_WIDTH-1:0] CONF_CENTER = 7'd100;

   typedef enum logic [1:0] {
      PT_POSITION = 2'd0,
      PT_WIDE     = 2'd1,
      PT_LOST     = 2'd2,
      PT_NOISE    = 2'd3
   } pattern_type_type;

   typedef struct packed {
      pattern_type_type              ptype;
      logic signed [POS_WIDTH-1:0]   mean;
      logic [CONF_WIDTH-1:0]         conf;
      logic                          reliable;
   } frame_info_type;

   function automatic pattern_type_type frame_class(input logic [FRAME_WIDTH-1:0] bits);
      pattern_type_type result;
      unique case (bits)
         4'h0:                               result = PT_LOST;
         4'h5, 4'h9, 4'hA, 4'hB, 4'hD:       result = PT_NOISE;
         4'h7, 4'hE, 4'hF:                   result = PT_WIDE;
         default:                            result = PT_POSITION;
      endcase
      return result;
   endfunction

   function automatic logic signed [POS_WIDTH-1:0] frame_mean(
      input logic [FRAME_WIDTH-1:0] bits);
      logic signed [POS_WIDTH-1:0] result;
      unique case (bits)
         4'h1:       result = -3'sd3;
         4'h2, 4'h7: result = -3'sd1;
         4'h3:       result = -3'sd2;
         4'h4, 4'hE: result = 3'sd1;
         4'h8:       result = 3'sd3;
         4'hC:       result = 3'sd2;
         default:    result = 3'sd0;
      endcase
      return result;
   endfunction

   function automatic logic [CONF_WIDTH-1:0] frame_conf(input logic [FRAME_WIDTH-1:0] bits);
      logic [CONF_WIDTH-1:0] result;
      unique case (bits)
         4'h6:       result = CONF_CENTER;
         4'h2, 4'h4: result = CONF_INNER;
         4'h3, 4'hC: result = CONF_PAIR;
         4'h1, 4'h8: result = CONF_EDGE;
         default:    result = CONF_NONE;
      endcase
      return result;
   endfunction

endpackage

/* src/line_sensor_position_tracker_unit.sv */
// Top level of the line sensor position tracker: input register, tracking state, result register.
// Depends on lspt_pkg and lspt_classify.
// An accepted word passes the input register and then the result register before it reaches rsp_.
// Throughput: one word per cycle while rsp_ready stays high; the tracking state updates
// as a frame moves from the input register into the result register.
// Reset: synchronous, active high; clears tracking state, registers to 1 and 3.
module line_sensor_position_tracker_unit import lspt_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [SENSOR_WIDTH-1:0]           req_sensor_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_pattern_type,
   output logic signed [POS_WIDTH-1:0]       rsp_stable_position,
   output logic signed [POS_WIDTH-1:0]       rsp_candidate_position,
   output logic [COUNT_WIDTH-1:0]            rsp_candidate_count,
   output logic [FRAME_WIDTH-1:0]            rsp_masked_bits,
   output logic signed [POS_WIDTH-1:0]       rsp_mean_error,
   output logic [CONF_WIDTH-1:0]             rsp_confidence,
   output logic                              rsp_reliable,
   input  logic                              csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]          csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]         csr_wdata
);

   logic [STEP_WIDTH-1:0]          adjacent_step_ff;
   logic [COUNT_WIDTH-1:0]         jump_accept_ff;

   logic                           in_valid_ff;
   logic [FRAME_WIDTH-1:0]         in_bits_ff;

   logic                           have_stable_ff, have_stable_in;
   logic signed [POS_WIDTH-1:0]    stable_pos_ff, stable_pos_in;
   logic signed [POS_WIDTH-1:0]    cand_pos_ff, cand_pos_in;
   logic [COUNT_WIDTH-1:0]         cand_frames_ff, cand_frames_in;

   logic                           rsp_valid_ff;
   logic [1:0]                     rsp_type_ff;
   logic signed [POS_WIDTH-1:0]    rsp_stable_ff, rsp_cand_ff, rsp_mean_ff;
   logic [COUNT_WIDTH-1:0]         rsp_count_ff;
   logic [FRAME_WIDTH-1:0]         rsp_bits_ff;
   logic [CONF_WIDTH-1:0]          rsp_conf_ff;
   logic                           rsp_rel_ff;

   frame_info_type                 info;
   logic                           out_free;
   logic                           advance;
   logic signed [POS_WIDTH:0]      delta;
   logic [POS_WIDTH-1:0]           delta_abs;
   logic                           cand_hit;

   lspt_classify u_classify (
      .frame_bits (in_bits_ff),
      .frame_info (info)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   assign delta     = {info.mean[POS_WIDTH-1], info.mean}
                    - {stable_pos_ff[POS_WIDTH-1], stable_pos_ff};
   assign delta_abs = delta[POS_WIDTH] ? POS_WIDTH'(-delta) : delta[POS_WIDTH-1:0];
   assign cand_hit  = (info.mean == cand_pos_ff) && (cand_frames_ff != '0);

   always_comb begin
      have_stable_in = have_stable_ff;
      stable_pos_in  = stable_pos_ff;
      cand_pos_in    = cand_pos_ff;
      cand_frames_in = cand_frames_ff;
      unique case (info.ptype)
         PT_WIDE: begin
            cand_pos_in    = info.mean;
            cand_frames_in = COUNT_WIDTH'(1);
         end
         PT_LOST, PT_NOISE: begin
            cand_pos_in    = stable_pos_ff;
            cand_frames_in = '0;
         end
         PT_POSITION: begin
            if (cand_hit) begin
               cand_frames_in = (cand_frames_ff == COUNT_MAX) ? COUNT_MAX
                                                              : cand_frames_ff + 1'b1;
            end else begin
               cand_pos_in    = info.mean;
               cand_frames_in = COUNT_WIDTH'(1);
            end
            if (!have_stable_ff || (delta_abs <= adjacent_step_ff) ||
                (cand_frames_in >= jump_accept_ff)) begin
               stable_pos_in  = info.mean;
               have_stable_in = 1'b1;
            end
         end
         default: begin
            cand_pos_in = cand_pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adjacent_step_ff <= ADJACENT_STEP_RESET;
         jump_accept_ff   <= JUMP_ACCEPT_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         have_stable_ff   <= 1'b0;
         stable_pos_ff    <= '0;
         cand_pos_ff      <= '0;
         cand_frames_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ADJACENT_STEP:      adjacent_step_ff <= csr_wdata[STEP_WIDTH-1:0];
               CSR_JUMP_ACCEPT_FRAMES: jump_accept_ff   <= csr_wdata[COUNT_WIDTH-1:0];
               default:                adjacent_step_ff <= adjacent_step_ff;
            endcase
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            have_stable_ff <= have_stable_in;
            stable_pos_ff  <= stable_pos_in;
            cand_pos_ff    <= cand_pos_in;
            cand_frames_ff <= cand_frames_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_bits_ff <= req_sensor_bits[FRAME_WIDTH-1:0];
      end
      if (advance) begin
         rsp_type_ff   <= info.ptype;
         rsp_stable_ff <= stable_pos_in;
         rsp_cand_ff   <= cand_pos_in;
         rsp_count_ff  <= cand_frames_in;
         rsp_bits_ff   <= in_bits_ff;
         rsp_mean_ff   <= info.reliable ? info.mean : stable_pos_in;
         rsp_conf_ff   <= info.conf;
         rsp_rel_ff    <= info.reliable;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pattern_type       = rsp_type_ff;
   assign rsp_stable_position    = rsp_stable_ff;
   assign rsp_candidate_position = rsp_cand_ff;
   assign rsp_candidate_count    = rsp_count_ff;
   assign rsp_masked_bits        = rsp_bits_ff;
   assign rsp_mean_error         = rsp_mean_ff;
   assign rsp_confidence         = rsp_conf_ff;
   assign rsp_reliable           = rsp_rel_ff;

endmodule

/* src/lspt_classify.sv */
// Frame classifier: run type, mean position and confidence of one four-bit frame.
// Depends on lspt_pkg.
module lspt_classify import lspt_pkg::*; (
   input  logic [FRAME_WIDTH-1:0] frame_bits,
   output frame_info_type         frame_info
);

   pattern_type_type ptype;

   assign ptype = frame_class(frame_bits);

   always_comb begin
      frame_info.ptype    = ptype;
      frame_info.mean     = frame_mean(frame_bits);
      frame_info.reliable = (ptype == PT_POSITION) || (ptype == PT_WIDE);
      unique case (ptype)
         PT_POSITION: frame_info.conf = frame_conf(frame_bits);
         PT_WIDE:     frame_info.conf = CONF_WIDE;
         PT_LOST,
         PT_NOISE:    frame_info.conf = CONF_NONE;
         default:     frame_info.conf = CONF_NONE;
      endcase
   end

endmodule

/* src/lspt_checker.sv */
// Port-level checker for the line sensor position tracker, bound to the top level.
// Depends on lspt_pkg and line_sensor_position_tracker_unit.
module lspt_checker import lspt_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [SENSOR_WIDTH-1:0]       req_sensor_bits,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_pattern_type,
   input logic signed [POS_WIDTH-1:0]   rsp_stable_position,
   input logic signed [POS_WIDTH-1:0]   rsp_candidate_position,
   input logic [COUNT_WIDTH-1:0]        rsp_candidate_count,
   input logic [FRAME_WIDTH-1:0]        rsp_masked_bits,
   input logic signed [POS_WIDTH-1:0]   rsp_mean_error,
   input logic [CONF_WIDTH-1:0]         rsp_confidence,
   input logic                          rsp_reliable
);

   a_lost_noise_resets_candidate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pattern_type == PT_LOST || rsp_pattern_type == PT_NOISE) |->
         rsp_candidate_count == '0 && rsp_candidate_position == rsp_stable_position &&
         rsp_mean_error == rsp_stable_position && rsp_confidence == CONF_NONE &&
         !rsp_reliable)
      else $error("lost or noise word left candidate or confidence set");

   a_wide_candidate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_type == PT_WIDE |->
         rsp_candidate_count == COUNT_WIDTH'(1) &&
         rsp_candidate_position == rsp_mean_error && rsp_confidence == CONF_WIDE)
      else $error("wide word candidate mismatch");

   a_position_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pattern_type == PT_POSITION |->
         rsp_candidate_count != '0 && rsp_candidate_position == rsp_mean_error &&
         rsp_reliable)
      else $error("position word without a live candidate");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_masked_bits) && $stable(rsp_candidate_count))
      else $error("result word changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sensor_bits))
      else $error("request word dropped or changed while waiting");

endmodule

bind line_sensor_position_tracker_unit lspt_checker u_lspt_checker (.*);
